@@ rtl/core/rlc_pkg.sv @@
// shared types and constants of the per-client rate limiter
package rlc_pkg;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 32;
  localparam int TIME_W   = 32;
  localparam int WIN_W    = 31;
  localparam int MAXR_W   = 16;
  localparam int CNT_W    = 17;
  localparam int TOTAL_W  = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 31;

  // s_tdata: client_id, now_ms
  localparam int IN_DATA_W  = 64;
  // m_tdata: 85 bits of fields padded to 88
  localparam int OUT_FIELD_W = 85;
  localparam int OUT_DATA_W  = 88;

  localparam logic [FUNC_W-1:0] FN_REQ    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FORGET = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXREQ = 1'd1;

  localparam logic [WIN_W-1:0]  WINDOW_RST = 31'd60000;
  localparam logic [MAXR_W-1:0] MAXREQ_RST = 16'd60;

  typedef struct packed {
    logic load;   // capture the accepted transaction
    logic look;   // id compare and free slot search
    logic calc;   // time and count evaluation
    logic upd;    // table write and result load
  } rlc_cmd_t;

  typedef struct packed {
    logic out_stall;  // result register full and not being taken
  } rlc_sts_t;

endpackage

@@ rtl/core/rlc_ctrl.sv @@
// sequencing controller of the rate limiter
module rlc_ctrl
  import rlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  rlc_sts_t sts,
  output rlc_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        // hold until the result register can take the new result
        if (!sts.out_stall) begin
          cmd.upd    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign s_tready = (state == S_IDLE);

endmodule

@@ rtl/core/rlc_dp.sv @@
// client table, time and count evaluation, counters and result register
module rlc_dp
  import rlc_pkg::*;
#(
  parameter int CLIENTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rlc_cmd_t               cmd,
  output rlc_sts_t               sts,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [ID_W-1:0]        in_id,
  input  logic [TIME_W-1:0]      in_now,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata
);

  localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

  // configuration
  logic [WIN_W-1:0]  window_ms;
  logic [MAXR_W-1:0] max_requests;

  // captured transaction
  logic [FUNC_W-1:0] func_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] now_q;

  // table
  logic [CLIENTS-1:0] entry_valid;
  logic [ID_W-1:0]    entry_id [CLIENTS];
  logic [CNT_W-1:0]   entry_count [CLIENTS];
  logic [TIME_W-1:0]  entry_ws [CLIENTS];
  logic               entry_blocked [CLIENTS];

  // lookup results
  logic          hit_c, free_c;
  logic [IW-1:0] hit_idx_c, free_idx_c;
  logic          hit, free_ok;
  logic [IW-1:0] hit_idx, free_idx;

  // evaluation results
  logic [TIME_W-1:0] diff_c;
  logic [CNT_W-1:0]  cnt_rd;
  logic [CNT_W-1:0]  cnt_inc_c;
  logic [CNT_W-1:0]  cnt_old, cnt_inc;
  logic              blk_old, in_block, win_over, over;

  logic [TOTAL_W-1:0] requests_seen;
  logic [TOTAL_W-1:0] requests_refused;

  // update decisions
  logic              wr_en, wr_new, forget_en, clear_en, refuse;
  logic [IW-1:0]     wr_idx;
  logic [CNT_W-1:0]  wr_cnt;
  logic              wr_blk;
  logic              res_allowed, res_blocked, res_new, res_full;
  logic [CNT_W-1:0]  res_count;

  logic [OUT_FIELD_W-1:0] out_q;
  logic                   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms    <= WINDOW_RST;
      max_requests <= MAXREQ_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_WINDOW: window_ms    <= cfg_wdata[WIN_W-1:0];
        REG_MAXREQ: max_requests <= cfg_wdata[MAXR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= in_func;
      id_q   <= in_id;
      now_q  <= in_now;
    end
  end

  // parallel id compare, lowest match and lowest free entry win
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = CLIENTS - 1; i >= 0; i--) begin
      if (entry_valid[i] && (entry_id[i] == id_q)) begin
        hit_c     = 1'b1;
        hit_idx_c = IW'(i);
      end
      if (!entry_valid[i]) begin
        free_c     = 1'b1;
        free_idx_c = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit      <= hit_c;
      hit_idx  <= hit_idx_c;
      free_ok  <= free_c;
      free_idx <= free_idx_c;
    end
  end

  assign diff_c    = now_q - entry_ws[hit_idx];
  assign cnt_rd    = entry_count[hit_idx];
  assign cnt_inc_c = (cnt_rd != '1) ? cnt_rd + CNT_W'(1) : cnt_rd;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      cnt_old  <= cnt_rd;
      cnt_inc  <= cnt_inc_c;
      blk_old  <= entry_blocked[hit_idx];
      in_block <= entry_blocked[hit_idx] &&
                  ({1'b0, diff_c} < {1'b0, window_ms, 1'b0});
      win_over <= (diff_c >= {1'b0, window_ms});
      over     <= (cnt_inc_c > {1'b0, max_requests});
    end
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_new      = 1'b0;
    wr_idx      = hit_idx;
    wr_cnt      = CNT_W'(1);
    wr_blk      = 1'b0;
    forget_en   = 1'b0;
    clear_en    = 1'b0;
    refuse      = 1'b0;
    res_allowed = 1'b1;
    res_blocked = 1'b0;
    res_new     = 1'b0;
    res_full    = 1'b0;
    res_count   = '0;
    case (func_q)
      FN_REQ: begin
        if (!hit) begin
          if (!free_ok) begin
            res_full = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_new    = 1'b1;
            wr_idx    = free_idx;
            res_new   = 1'b1;
            res_count = CNT_W'(1);
          end
        end else if (in_block) begin
          refuse      = 1'b1;
          res_allowed = 1'b0;
          res_count   = cnt_old;
          res_blocked = blk_old;
        end else if (win_over) begin
          // window has run out: fresh window from now
          wr_en     = 1'b1;
          res_count = CNT_W'(1);
        end else begin
          wr_en       = 1'b1;
          wr_cnt      = cnt_inc;
          wr_blk      = blk_old | over;
          refuse      = over;
          res_allowed = !over;
          res_count   = cnt_inc;
          res_blocked = blk_old | over;
        end
      end
      FN_FORGET: begin
        forget_en = hit;
      end
      FN_CLEAR: begin
        clear_en = 1'b1;
      end
      FN_QUERY: begin
        if (hit) begin
          res_count   = cnt_old;
          res_blocked = blk_old;
          res_allowed = !blk_old;
        end
      end
      default: ;
    endcase
  end

  // entry payload, no reset: only read behind a valid bit
  always_ff @(posedge clk) begin
    if (cmd.upd && wr_en) begin
      entry_count[wr_idx]   <= wr_cnt;
      entry_blocked[wr_idx] <= wr_blk;
      if (wr_new || (wr_cnt == CNT_W'(1) && !wr_blk && win_over)) begin
        entry_ws[wr_idx] <= now_q;
      end
      if (wr_new) begin
        entry_id[wr_idx] <= id_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid      <= '0;
      requests_seen    <= '0;
      requests_refused <= '0;
    end else if (cmd.upd) begin
      if (clear_en) begin
        entry_valid <= '0;
      end else if (forget_en) begin
        entry_valid[hit_idx] <= 1'b0;
      end else if (wr_new) begin
        entry_valid[free_idx] <= 1'b1;
      end
      if (func_q == FN_REQ) begin
        requests_seen <= requests_seen + TOTAL_W'(1);
      end
      if (refuse) begin
        requests_refused <= requests_refused + TOTAL_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_q <= {
        (func_q == FN_REQ) ? requests_refused + TOTAL_W'(refuse) : requests_refused,
        (func_q == FN_REQ) ? requests_seen + TOTAL_W'(1) : requests_seen,
        res_full, res_new, res_count, res_blocked, res_allowed
      };
    end
  end

  assign sts.out_stall = out_valid && !m_tready;
  assign m_tvalid      = out_valid;
  assign m_tdata       = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}}, out_q};

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd && func_q == FN_CLEAR) |=> (entry_valid == '0))
    else $error("table not empty after clear");

  a_refused_only_on_request: assert property (@(posedge clk) disable iff (rst)
    !(cmd.upd && func_q == FN_REQ) |=> $stable(requests_refused))
    else $error("refused counter moved outside a request");

  a_refused_has_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd && func_q == FN_REQ && !res_allowed) |-> (res_count != '0 && res_blocked))
    else $error("refused request without a blocked, counted client");

endmodule

@@ rtl/core/per_client_rate_limiter_core.sv @@
// Per-client fixed-window rate limiter: CLIENTS-entry table of numeric ids, each with a
// request count, window start and blocked flag. A transaction goes from acceptance to its
// result through the controller's steps (capture, parallel id compare, time and count
// evaluation, table update); s_tready returns in the cycle the result is loaded, and the
// next transaction is taken while that result still waits on the master side. A result
// that is not taken holds the update step until the register frees. When the table is
// full a new client is allowed, not stored, and table_full is set. The user must write
// window_ms and max_requests only while the block is idle; the block does not enforce it.
module per_client_rate_limiter_core
  import rlc_pkg::*;
#(
  parameter int CLIENTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,   // 0 window_ms, 1 max_requests
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,     // client_id[31:0], now_ms[63:32]
  input  logic [FUNC_W-1:0]     s_tuser,     // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata      // allowed, client_blocked, request_count[18:2],
                                             // new_client, table_full, total_count[52:21],
                                             // refused_count[84:53], zero pad
);

  rlc_cmd_t cmd;
  rlc_sts_t sts;

  rlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlc_dp #(
    .CLIENTS (CLIENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_func   (s_tuser),
    .in_id     (s_tdata[ID_W-1:0]),
    .in_now    (s_tdata[ID_W+TIME_W-1:ID_W]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> !(m_tvalid && !m_tready))
    else $error("result register overwritten before transaction");

endmodule
